// ===== hw/rtl/crla_pkg.sv =====
// Shared constants, types and codes of the color region labeler.
`timescale 1ns / 1ps
package crla_pkg;

  localparam int MAX_SEGMENTS  = 256;
  localparam int ID_W          = $clog2(MAX_SEGMENTS);
  localparam int USED_W        = ID_W + 1;
  localparam int MAX_ROW_WIDTH = 1024;
  localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
  localparam int CFG_W         = 11;
  localparam int COUNT_BITS    = 24;
  localparam int WIDTH_RESET   = 640;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_COUNT = 2'd1,
    ACT_ADJ   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PAIR_LEFT_AB = 2'd0,
    PAIR_LEFT_BA = 2'd1,
    PAIR_UP_AB   = 2'd2,
    PAIR_UP_BA   = 2'd3
  } pair_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SZRD,
    ST_SZWR,
    ST_ADRD,
    ST_ADWR,
    ST_QCNT,
    ST_QADJ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             latch;
    logic             clear_frame;
    logic             clr_wr;
    logic [COL_W-1:0] clr_addr;
    logic [ID_W-1:0]  srch_addr;
    logic             color_rd;
    logic             found;
    logic             new_seg;
    logic             ovf;
    logic             sz_rd;
    logic             sz_wr;
    logic             adj_rd;
    logic             adj_wr;
    pair_op_e         adj_op;
    logic             done;
  } cmd_t;

  typedef struct packed {
    logic              match;
    logic              full;
    logic              left_vld;
    logic              up_vld;
    logic [USED_W-1:0] used;
  } status_t;

endpackage

// ===== hw/rtl/crla_ctrl.sv =====
// Controller state machine of the color region labeler.
`timescale 1ns / 1ps
module crla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  crla_pkg::action_e   action_i,
  input  crla_pkg::status_t   status_i,
  output crla_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  crla_pkg::state_e                state_q, state_d;
  logic [crla_pkg::COL_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [crla_pkg::USED_W-1:0]     k_q, k_d;
  crla_pkg::pair_op_e              op_q, op_d;
  logic                            clr_act_q, clr_act_d;
  logic                            op_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crla_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      k_q       <= '0;
      op_q      <= crla_pkg::PAIR_LEFT_AB;
      clr_act_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      k_q       <= k_d;
      op_q      <= op_d;
      clr_act_q <= clr_act_d;
    end
  end

  assign op_en = (op_q == crla_pkg::PAIR_UP_AB || op_q == crla_pkg::PAIR_UP_BA) ?
                 status_i.up_vld : status_i.left_vld;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    k_d       = k_q;
    op_d      = op_q;
    clr_act_d = clr_act_q;
    cmd_o     = '0;
    cmd_o.clr_addr  = clr_cnt_q;
    cmd_o.srch_addr = k_q[crla_pkg::ID_W-1:0];
    cmd_o.adj_op    = op_q;
    busy_o    = 1'b1;
    case (state_q)
      crla_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == crla_pkg::COL_W'(crla_pkg::MAX_ROW_WIDTH - 1)) begin
          cmd_o.done = clr_act_q;
          clr_act_d  = 1'b0;
          state_d    = crla_pkg::ST_IDLE;
        end
      end
      crla_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          case (action_i)
            crla_pkg::ACT_PIXEL: begin
              k_d     = '0;
              state_d = crla_pkg::ST_RD;
            end
            crla_pkg::ACT_COUNT: state_d = crla_pkg::ST_QCNT;
            crla_pkg::ACT_ADJ:   state_d = crla_pkg::ST_QADJ;
            default: begin
              cmd_o.clear_frame = 1'b1;
              clr_cnt_d         = '0;
              clr_act_d         = 1'b1;
              state_d           = crla_pkg::ST_CLEAR;
            end
          endcase
        end
      end
      crla_pkg::ST_RD: begin
        if (k_q < status_i.used) begin
          cmd_o.color_rd = 1'b1;
          state_d        = crla_pkg::ST_CMP;
        end else if (status_i.full) begin
          cmd_o.ovf = 1'b1;
          state_d   = crla_pkg::ST_DONE;
        end else begin
          cmd_o.new_seg = 1'b1;
          state_d       = crla_pkg::ST_SZRD;
        end
      end
      crla_pkg::ST_CMP: begin
        if (status_i.match) begin
          cmd_o.found = 1'b1;
          state_d     = crla_pkg::ST_SZRD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = crla_pkg::ST_RD;
        end
      end
      crla_pkg::ST_SZRD: begin
        cmd_o.sz_rd = 1'b1;
        state_d     = crla_pkg::ST_SZWR;
      end
      crla_pkg::ST_SZWR: begin
        cmd_o.sz_wr = 1'b1;
        op_d        = crla_pkg::PAIR_LEFT_AB;
        state_d     = crla_pkg::ST_ADRD;
      end
      crla_pkg::ST_ADRD: begin
        if (op_en) begin
          cmd_o.adj_rd = 1'b1;
          state_d      = crla_pkg::ST_ADWR;
        end else if (op_q == crla_pkg::PAIR_UP_BA) begin
          state_d = crla_pkg::ST_DONE;
        end else begin
          op_d = crla_pkg::pair_op_e'(op_q + 2'd1);
        end
      end
      crla_pkg::ST_ADWR: begin
        cmd_o.adj_wr = 1'b1;
        if (op_q == crla_pkg::PAIR_UP_BA) begin
          state_d = crla_pkg::ST_DONE;
        end else begin
          op_d    = crla_pkg::pair_op_e'(op_q + 2'd1);
          state_d = crla_pkg::ST_ADRD;
        end
      end
      crla_pkg::ST_QCNT: begin
        cmd_o.sz_rd = 1'b1;
        state_d     = crla_pkg::ST_DONE;
      end
      crla_pkg::ST_QADJ: begin
        cmd_o.adj_rd = 1'b1;
        state_d      = crla_pkg::ST_DONE;
      end
      crla_pkg::ST_DONE: begin
        cmd_o.done = 1'b1;
        state_d    = crla_pkg::ST_IDLE;
      end
      default: state_d = crla_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/crla_dp.sv =====
// Datapath of the color region labeler: tables, row labels and result registers.
`timescale 1ns / 1ps
module crla_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  crla_pkg::cmd_t                    cmd_i,
  output crla_pkg::status_t                 status_o,
  input  crla_pkg::action_e                 action_i,
  input  logic [7:0]                        red_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        blue_i,
  input  logic [crla_pkg::ID_W-1:0]         query_first_i,
  input  logic [crla_pkg::ID_W-1:0]         query_second_i,
  input  logic                              width_we_i,
  input  logic [crla_pkg::CFG_W-1:0]        width_i,
  output logic                              done_o,
  output logic [crla_pkg::ID_W-1:0]         segment_id_o,
  output logic                              new_segment_o,
  output logic                              overflow_o,
  output logic [crla_pkg::COUNT_BITS-1:0]   pixel_count_o,
  output logic                              adjacent_o,
  output logic [crla_pkg::USED_W-1:0]       segments_in_use_o
);

  localparam int NS = crla_pkg::MAX_SEGMENTS;
  localparam int IW = crla_pkg::ID_W;
  localparam int CW = crla_pkg::COUNT_BITS;

  logic [crla_pkg::CFG_W-1:0]  cfg_width_q;
  crla_pkg::action_e           act_q;
  logic [23:0]                 key_q;
  logic [IW-1:0]               q1_q, q2_q;

  logic [23:0]                 color_mem [NS];
  logic [23:0]                 color_rd_q;
  logic [crla_pkg::USED_W-1:0] used_q;

  logic [CW-1:0]               size_mem [NS];
  logic [CW-1:0]               size_rd_q;
  logic                        size_rd_vld_q;
  logic [NS-1:0]               size_vld_q;

  logic [NS-1:0]               adj_mem [NS];
  logic [NS-1:0]               adj_rd_q;
  logic                        adj_rd_vld_q;
  logic [NS-1:0]               adj_vld_q;

  logic [IW:0]                 up_mem [crla_pkg::MAX_ROW_WIDTH];
  logic [IW:0]                 up_rd_q;

  logic [IW-1:0]               left_q;
  logic                        left_vld_q;
  logic [crla_pkg::COL_W-1:0]  col_q;
  logic                        first_q;
  logic [IW-1:0]               id_q;
  logic                        fresh_q, ovf_q;

  logic [IW-1:0]               sz_addr, adj_row, adj_bit;
  logic [CW-1:0]               sz_wdata;
  logic [NS-1:0]               adj_onehot, adj_wdata;
  logic [crla_pkg::CFG_W-1:0]  width_eff, col_nxt;
  logic                        wrap, pix_done;
  logic [IW:0]                 up_wdata;
  logic [crla_pkg::COL_W-1:0]  up_waddr;

  assign status_o.match    = (color_rd_q == key_q);
  assign status_o.full     = (used_q == crla_pkg::USED_W'(NS));
  assign status_o.left_vld = left_vld_q;
  assign status_o.up_vld   = !first_q && up_rd_q[IW];
  assign status_o.used     = used_q;

  always_comb begin
    if (cfg_width_q < crla_pkg::CFG_W'(2)) begin
      width_eff = crla_pkg::CFG_W'(2);
    end else if (cfg_width_q > crla_pkg::CFG_W'(crla_pkg::MAX_ROW_WIDTH)) begin
      width_eff = crla_pkg::CFG_W'(crla_pkg::MAX_ROW_WIDTH);
    end else begin
      width_eff = cfg_width_q;
    end
  end

  assign col_nxt  = {1'b0, col_q} + crla_pkg::CFG_W'(1);
  assign wrap     = (col_nxt >= width_eff);
  assign pix_done = cmd_i.done && (act_q == crla_pkg::ACT_PIXEL);
  assign sz_addr  = (act_q == crla_pkg::ACT_COUNT) ? q1_q : id_q;
  assign sz_wdata = !size_rd_vld_q ? CW'(1) :
                    (&size_rd_q) ? size_rd_q : size_rd_q + CW'(1);

  always_comb begin
    case (cmd_i.adj_op)
      crla_pkg::PAIR_LEFT_AB: begin
        adj_row = left_q;
        adj_bit = id_q;
      end
      crla_pkg::PAIR_LEFT_BA: begin
        adj_row = id_q;
        adj_bit = left_q;
      end
      crla_pkg::PAIR_UP_AB: begin
        adj_row = up_rd_q[IW-1:0];
        adj_bit = id_q;
      end
      default: begin
        adj_row = id_q;
        adj_bit = up_rd_q[IW-1:0];
      end
    endcase
    if (act_q == crla_pkg::ACT_ADJ) begin
      adj_row = q1_q;
      adj_bit = q2_q;
    end
    adj_onehot          = '0;
    adj_onehot[adj_bit] = 1'b1;
    adj_wdata           = (adj_rd_vld_q ? adj_rd_q : '0) | adj_onehot;
  end

  assign up_waddr = cmd_i.clr_wr ? cmd_i.clr_addr : col_q;
  assign up_wdata = cmd_i.clr_wr ? '0 : {!ovf_q, id_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= crla_pkg::CFG_W'(crla_pkg::WIDTH_RESET);
      used_q      <= '0;
      size_vld_q  <= '0;
      adj_vld_q   <= '0;
      left_vld_q  <= 1'b0;
      left_q      <= '0;
      col_q       <= '0;
      first_q     <= 1'b1;
      done_o      <= 1'b0;
    end else begin
      done_o <= cmd_i.done;
      if (width_we_i) begin
        cfg_width_q <= width_i;
      end
      if (cmd_i.clear_frame) begin
        used_q     <= '0;
        size_vld_q <= '0;
        adj_vld_q  <= '0;
        left_vld_q <= 1'b0;
        left_q     <= '0;
        col_q      <= '0;
        first_q    <= 1'b1;
      end
      if (cmd_i.new_seg) begin
        used_q <= used_q + 1'b1;
      end
      if (cmd_i.sz_wr) begin
        size_vld_q[id_q] <= 1'b1;
      end
      if (cmd_i.adj_wr) begin
        adj_vld_q[adj_row] <= 1'b1;
      end
      if (pix_done) begin
        if (wrap) begin
          col_q      <= '0;
          first_q    <= 1'b0;
          left_vld_q <= 1'b0;
          left_q     <= '0;
        end else begin
          col_q      <= col_nxt[crla_pkg::COL_W-1:0];
          left_vld_q <= !ovf_q;
          left_q     <= id_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= action_i;
      key_q   <= {red_i, green_i, blue_i};
      q1_q    <= query_first_i;
      q2_q    <= query_second_i;
      fresh_q <= 1'b0;
      ovf_q   <= 1'b0;
      id_q    <= '0;
    end
    if (cmd_i.found) begin
      id_q <= cmd_i.srch_addr;
    end
    if (cmd_i.new_seg) begin
      id_q    <= used_q[IW-1:0];
      fresh_q <= 1'b1;
    end
    if (cmd_i.ovf) begin
      ovf_q <= 1'b1;
    end
    if (cmd_i.done) begin
      segment_id_o      <= (act_q == crla_pkg::ACT_PIXEL && !ovf_q) ? id_q : '0;
      new_segment_o     <= (act_q == crla_pkg::ACT_PIXEL) && fresh_q;
      overflow_o        <= (act_q == crla_pkg::ACT_PIXEL) && ovf_q;
      pixel_count_o     <= (act_q == crla_pkg::ACT_COUNT && size_rd_vld_q) ?
                           size_rd_q : '0;
      adjacent_o        <= (act_q == crla_pkg::ACT_ADJ) && adj_rd_vld_q && adj_rd_q[q2_q];
      segments_in_use_o <= used_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.new_seg) begin
      color_mem[used_q[IW-1:0]] <= key_q;
    end
    if (cmd_i.color_rd) begin
      color_rd_q <= color_mem[cmd_i.srch_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sz_wr) begin
      size_mem[id_q] <= sz_wdata;
    end
    if (cmd_i.sz_rd) begin
      size_rd_q     <= size_mem[sz_addr];
      size_rd_vld_q <= size_vld_q[sz_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adj_wr) begin
      adj_mem[adj_row] <= adj_wdata;
    end
    if (cmd_i.adj_rd) begin
      adj_rd_q     <= adj_mem[adj_row];
      adj_rd_vld_q <= adj_vld_q[adj_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr || pix_done) begin
      up_mem[up_waddr] <= up_wdata;
    end
    up_rd_q <= up_mem[col_q];
  end

endmodule

// ===== hw/rtl/color_region_labeler_adjacency.sv =====
// Top level of the color region labeler with segment adjacency tracking.
//
// Requests enter on start_i while busy_o is low; action_i selects pixel,
// count read, adjacency read or frame clear. Each request gives exactly one
// result, shown for one cycle with done_o high; the receiver cannot stall.
// A pixel searches the color table entry by entry, reading each entry and
// then comparing it with the pixel color. On a match, or after a new entry
// is made when none matches, it updates that segment's pixel count by a
// read-modify-write and then makes up to four adjacency row
// read-modify-writes. A pixel that finds the table full goes on to its
// result with no update. Count and adjacency reads make one table read each.
// A clear, and the period after reset, sweeps the 1024-entry upper-row label
// memory one entry a cycle with busy_o high; a clear gives its result at the
// end of the sweep. The next request is taken in the cycle the result shows.
// The user must write image_width through width_we_i and width_i only while
// the block is idle; the block does not enforce this. Reset loads 640.
`timescale 1ns / 1ps
module color_region_labeler_adjacency (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        action_i,
  input  logic [7:0]                        red_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        blue_i,
  input  logic [crla_pkg::ID_W-1:0]         query_first_i,
  input  logic [crla_pkg::ID_W-1:0]         query_second_i,
  input  logic                              width_we_i,
  input  logic [crla_pkg::CFG_W-1:0]        width_i,
  output logic                              done_o,
  output logic [crla_pkg::ID_W-1:0]         segment_id_o,
  output logic                              new_segment_o,
  output logic                              overflow_o,
  output logic [crla_pkg::COUNT_BITS-1:0]   pixel_count_o,
  output logic                              adjacent_o,
  output logic [crla_pkg::USED_W-1:0]       segments_in_use_o
);

  crla_pkg::cmd_t    cmd;
  crla_pkg::status_t status;
  crla_pkg::action_e action;

  assign action = crla_pkg::action_e'(action_i);

  crla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  crla_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .action_i          (action),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .query_first_i     (query_first_i),
    .query_second_i    (query_second_i),
    .width_we_i        (width_we_i),
    .width_i           (width_i),
    .done_o            (done_o),
    .segment_id_o      (segment_id_o),
    .new_segment_o     (new_segment_o),
    .overflow_o        (overflow_o),
    .pixel_count_o     (pixel_count_o),
    .adjacent_o        (adjacent_o),
    .segments_in_use_o (segments_in_use_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after request");

  a_ovf_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(overflow_o && new_segment_o))
    else $error("overflow together with new segment");

  a_ovf_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflow_o |-> segment_id_o == '0 &&
      segments_in_use_o == crla_pkg::USED_W'(crla_pkg::MAX_SEGMENTS))
    else $error("overflow with labeled pixel or table not full");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> segments_in_use_o <= crla_pkg::USED_W'(crla_pkg::MAX_SEGMENTS))
    else $error("segment count out of range");

endmodule
